/* design/ffha_pkg.sv */
//==============================================================================
// ffha_pkg
// Shared constants for the first-fit heap allocator.
//==============================================================================
package ffha_pkg;

    localparam int ARENA_GRANULES_DEF  = 8192;
    localparam int HEADER_GRANULES_DEF = 3;

    // Request codes carried in the action field.
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_RESIZE  = 2'd2;

    // Result codes carried in the status field.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;

endpackage

/* design/ffha_ram.sv */
//==============================================================================
// ffha_ram
// Generic single-port synchronous RAM with a registered read.
//==============================================================================
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle; read data is registered and appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/first_fit_heap_allocator_unit.sv */
// A moving resize performs both an allocate and a release.
// Throughput: one request at a time; the next beat is taken once the result beat
// has left. After reset, the INIT state writes header entry 0 before going idle.
//==============================================================================
// first_fit_heap_allocator_unit
// First-fit free-list allocator with address-ordered list and coalescing.
//==============================================================================
module first_fit_heap_allocator_unit #(
    parameter int ARENA_GRANULES  = ffha_pkg::ARENA_GRANULES_DEF,
    parameter int HEADER_GRANULES = ffha_pkg::HEADER_GRANULES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] action, [18:2] size_bytes, [34:19] address, rest zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] result_address, [17:16] status, rest zero
    output logic [23:0] m_tdata
);
    import ffha_pkg::*;

    localparam int AW = $clog2(ARENA_GRANULES);
    localparam int LW = AW + 1;            // link width, NIL = ARENA_GRANULES
    localparam int SW = AW + 1;            // size width, saturates at ARENA_GRANULES
    localparam int HW = SW + LW + 1;
    localparam int WW = 15;                // rounded request of up to 2^17 - 1 bytes
    localparam int XW = ((LW > WW) ? LW : WW) + 2;
    localparam logic [LW-1:0] NIL = LW'(ARENA_GRANULES);
    localparam logic [SW-1:0] HG  = SW'(HEADER_GRANULES);

    typedef struct packed {
        logic [SW-1:0] size;
        logic [LW-1:0] next;
        logic          free;
    } hdr_t;

    typedef enum logic [20:0] {
        S_INIT   = 21'd1 << 0,
        S_IDLE   = 21'd1 << 1,
        S_DEC    = 21'd1 << 2,
        S_RZRD   = 21'd1 << 3,
        S_RZCHK  = 21'd1 << 4,
        S_TKRD   = 21'd1 << 5,
        S_TKCHK  = 21'd1 << 6,
        S_TKSPL  = 21'd1 << 7,
        S_SPWR   = 21'd1 << 8,
        S_TKOWN  = 21'd1 << 9,
        S_GBRD   = 21'd1 << 10,
        S_GBCHK  = 21'd1 << 11,
        S_LKTST  = 21'd1 << 12,
        S_LKCHK  = 21'd1 << 13,
        S_LKEND  = 21'd1 << 14,
        S_LKPRV  = 21'd1 << 15,
        S_MGST   = 21'd1 << 16,
        S_MGCUR  = 21'd1 << 17,
        S_MGTST  = 21'd1 << 18,
        S_MGNX   = 21'd1 << 19,
        S_OUT    = 21'd1 << 20
    } state_t;

    // Header RAM port.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    hdr_t          ram_wdata;
    hdr_t          ram_rdata;

    ffha_ram #(.WIDTH(HW), .DEPTH(ARENA_GRANULES)) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    state_t        state_reg, state_next;
    logic [LW-1:0] head_reg, head_next;
    logic [1:0]    act_reg, act_next;
    logic [WW-1:0] want_reg, want_next;      // rounded request in granules
    logic [12:0]   pg_reg, pg_next;           // payload granule of the address
    logic [LW-1:0] g_reg, g_next;             // block under release or resize
    logic [LW-1:0] prev_reg, prev_next;
    hdr_t          prevh_reg, prevh_next;     // header of prev
    logic [LW-1:0] cur_reg, cur_next;
    hdr_t          curh_reg, curh_next;       // header of cur
    logic [LW-1:0] lnk_reg, lnk_next;         // block being linked
    hdr_t          lnkh_reg, lnkh_next;       // header of the block being linked
    logic          lktake_reg, lktake_next;   // link done on behalf of a split
    logic [LW-1:0] tk_reg, tk_next;           // block taken by allocate
    logic [SW-1:0] tksz_reg, tksz_next;       // final size of the taken block
    logic          gbafter_reg, gbafter_next; // release old block after a move
    logic [15:0]   res_reg, res_next;
    logic [1:0]    st_reg, st_next;
    logic          ovalid_reg, ovalid_next;

    logic [1:0]    in_act;
    logic [16:0]   in_bytes;
    logic [15:0]   in_addr;
    logic          dec_null;
    logic [LW-1:0] dec_g;
    logic          fits;
    logic          split_ok;
    logic [XW-1:0] rest_at;
    logic [XW-1:0] blk_end;
    logic [XW-1:0] msum;

    assign in_act   = s_tdata[1:0];
    assign in_bytes = s_tdata[18:2];
    assign in_addr  = s_tdata[34:19];

    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {6'd0, st_reg, res_reg};

    // Address decoding: a header inside the first header or past the arena is null.
    assign dec_null = (32'(pg_reg) < 32'(HEADER_GRANULES)) ||
                      (32'(pg_reg) - 32'(HEADER_GRANULES) >= 32'(ARENA_GRANULES));
    assign dec_g    = dec_null ? '0 : LW'(32'(pg_reg) - 32'(HEADER_GRANULES));

    // Size arithmetic on the cached and the freshly read headers.
    assign fits     = XW'(ram_rdata.size) >= XW'(want_reg);
    assign rest_at  = XW'(tk_reg) + XW'(HG) + XW'(want_reg);
    assign split_ok = (XW'(curh_reg.size) >= XW'(want_reg) + XW'(2 * HEADER_GRANULES + 1))
                      && (rest_at < XW'(NIL));
    assign blk_end  = XW'(cur_reg) + XW'(HG) + XW'(curh_reg.size);
    assign msum     = XW'(curh_reg.size) + XW'(HG) + XW'(ram_rdata.size);

    // Sequencer: every header access is a registered read whose data is used in the next state, or a write.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        act_next     = act_reg;
        want_next    = want_reg;
        pg_next      = pg_reg;
        g_next       = g_reg;
        prev_next    = prev_reg;
        prevh_next   = prevh_reg;
        cur_next     = cur_reg;
        curh_next    = curh_reg;
        lnk_next     = lnk_reg;
        lnkh_next    = lnkh_reg;
        lktake_next  = lktake_reg;
        tk_next      = tk_reg;
        tksz_next    = tksz_reg;
        gbafter_next = gbafter_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        ovalid_next  = ovalid_reg;
        ram_we       = 1'b0;
        ram_addr     = cur_reg[AW-1:0];
        ram_wdata    = curh_reg;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we     = 1'b1;
                ram_addr   = '0;
                ram_wdata  = '{size: SW'(ARENA_GRANULES - HEADER_GRANULES), next: NIL,
                               free: 1'b1};
                head_next  = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    act_next   = in_act;
                    want_next  = WW'(({1'b0, in_bytes} + 18'd7) >> 3);
                    pg_next    = in_addr[15:3];
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                g_next       = dec_g;
                res_next     = '0;
                st_next      = ST_DONE;
                gbafter_next = 1'b0;
                if (act_reg == ACT_RELEASE)
                begin
                    if (dec_null)
                    begin
                        st_next    = ST_NULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_GBRD;
                    end
                end
                else if (act_reg == ACT_ALLOC || dec_null)
                begin
                    if (want_reg == '0)
                    begin
                        st_next    = ST_NULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        prev_next  = NIL;
                        cur_next   = head_reg;
                        st_next    = ST_OOM;
                        state_next = (head_reg < NIL) ? S_TKRD : S_OUT;
                    end
                end
                else if (want_reg == '0)
                begin
                    st_next    = ST_NULL;
                    state_next = S_GBRD;
                end
                else
                begin
                    state_next = S_RZRD;
                end
            end
            // Resize: shrink in place, else move.
            S_RZRD:
            begin
                ram_addr   = g_reg[AW-1:0];
                state_next = S_RZCHK;
            end
            S_RZCHK:
            begin
                if (fits)
                begin
                    ram_we     = 1'b1;
                    ram_addr   = g_reg[AW-1:0];
                    ram_wdata  = '{size: SW'(want_reg), next: ram_rdata.next,
                                   free: ram_rdata.free};
                    res_next   = {pg_reg, 3'd0};
                    state_next = S_OUT;
                end
                else
                begin
                    gbafter_next = 1'b1;
                    prev_next    = NIL;
                    cur_next     = head_reg;
                    st_next      = ST_OOM;
                    state_next   = (head_reg < NIL) ? S_TKRD : S_OUT;
                end
            end
            // First-fit walk; the next header is read while this one is checked.
            S_TKRD:
            begin
                ram_addr   = cur_reg[AW-1:0];
                state_next = S_TKCHK;
            end
            S_TKCHK:
            begin
                curh_next = ram_rdata;
                if (ram_rdata.free && fits)
                begin
                    tk_next   = cur_reg;
                    tksz_next = ram_rdata.size;
                    if (prev_reg >= NIL)
                    begin
                        head_next = ram_rdata.next;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_addr  = prev_reg[AW-1:0];
                        ram_wdata = '{size: prevh_reg.size, next: ram_rdata.next,
                                      free: prevh_reg.free};
                    end
                    state_next = S_TKSPL;
                end
                else
                begin
                    prev_next  = cur_reg;
                    prevh_next = ram_rdata;
                    cur_next   = ram_rdata.next;
                    if (ram_rdata.next < NIL)
                    begin
                        ram_addr   = ram_rdata.next[AW-1:0];
                        state_next = S_TKCHK;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            // Split off the tail when it can hold a header and one granule.
            S_TKSPL:
            begin
                if (split_ok)
                begin
                    ram_addr   = rest_at[AW-1:0];
                    state_next = S_SPWR;
                end
                else
                begin
                    state_next = S_TKOWN;
                end
            end
            S_SPWR:
            begin
                lnkh_next   = '{size: SW'(XW'(curh_reg.size) - XW'(want_reg) - XW'(HG)),
                                next: ram_rdata.next, free: 1'b1};
                ram_we      = 1'b1;
                ram_addr    = rest_at[AW-1:0];
                ram_wdata   = lnkh_next;
                lnk_next    = LW'(rest_at);
                tksz_next   = SW'(want_reg);
                lktake_next = 1'b1;
                prev_next   = NIL;
                cur_next    = head_reg;
                state_next  = S_LKTST;
            end
            S_TKOWN:
            begin
                ram_we     = 1'b1;
                ram_addr   = tk_reg[AW-1:0];
                ram_wdata  = '{size: tksz_reg, next: NIL, free: 1'b0};
                res_next   = 16'((32'(tk_reg) + 32'(HEADER_GRANULES)) << 3);
                st_next    = ST_DONE;
                state_next = gbafter_reg ? S_GBRD : S_OUT;
            end
            // Release: ignore a block already free.
            S_GBRD:
            begin
                ram_addr   = g_reg[AW-1:0];
                state_next = S_GBCHK;
            end
            S_GBCHK:
            begin
                if (ram_rdata.free)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    lnkh_next   = '{size: ram_rdata.size, next: ram_rdata.next, free: 1'b1};
                    ram_we      = 1'b1;
                    ram_addr    = g_reg[AW-1:0];
                    ram_wdata   = lnkh_next;
                    lnk_next    = g_reg;
                    lktake_next = 1'b0;
                    prev_next   = NIL;
                    cur_next    = head_reg;
                    state_next  = S_LKTST;
                end
            end
            // Ordered insert: walk while cur < lnk.
            S_LKTST:
            begin
                if (cur_reg < NIL && cur_reg < lnk_reg)
                begin
                    ram_addr   = cur_reg[AW-1:0];
                    state_next = S_LKCHK;
                end
                else
                begin
                    state_next = S_LKEND;
                end
            end
            S_LKCHK:
            begin
                prev_next  = cur_reg;
                prevh_next = ram_rdata;
                cur_next   = ram_rdata.next;
                if (ram_rdata.next < NIL && ram_rdata.next < lnk_reg)
                begin
                    ram_addr   = ram_rdata.next[AW-1:0];
                    state_next = S_LKCHK;
                end
                else
                begin
                    state_next = S_LKEND;
                end
            end
            S_LKEND:
            begin
                if (cur_reg == lnk_reg)
                begin
                    state_next = lktake_reg ? S_TKOWN : S_MGST;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_addr  = lnk_reg[AW-1:0];
                    ram_wdata = '{size: lnkh_reg.size, next: (cur_reg < NIL) ? cur_reg : NIL,
                                  free: lnkh_reg.free};
                    if (prev_reg >= NIL)
                    begin
                        head_next  = lnk_reg;
                        state_next = lktake_reg ? S_TKOWN : S_MGST;
                    end
                    else
                    begin
                        state_next = S_LKPRV;
                    end
                end
            end
            S_LKPRV:
            begin
                ram_we     = 1'b1;
                ram_addr   = prev_reg[AW-1:0];
                ram_wdata  = '{size: prevh_reg.size, next: lnk_reg, free: prevh_reg.free};
                state_next = lktake_reg ? S_TKOWN : S_MGST;
            end
            // Merge pass over the whole list.
            S_MGST:
            begin
                cur_next = head_reg;
                if (head_reg < NIL)
                begin
                    ram_addr   = head_reg[AW-1:0];
                    state_next = S_MGCUR;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MGCUR:
            begin
                curh_next  = ram_rdata;
                state_next = S_MGTST;
            end
            S_MGTST:
            begin
                if (curh_reg.next >= NIL)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ram_addr = curh_reg.next[AW-1:0];
                    if (blk_end == XW'(curh_reg.next))
                    begin
                        state_next = S_MGNX;
                    end
                    else
                    begin
                        cur_next   = curh_reg.next;
                        state_next = S_MGCUR;
                    end
                end
            end
            S_MGNX:
            begin
                curh_next.size = (msum > XW'(ARENA_GRANULES)) ? SW'(ARENA_GRANULES)
                                                              : SW'(msum);
                curh_next.next = ram_rdata.next;
                ram_we         = 1'b1;
                ram_addr       = cur_reg[AW-1:0];
                ram_wdata      = curh_next;
                state_next     = S_MGTST;
            end
            S_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            head_reg    <= '0;
            ovalid_reg  <= 1'b0;
            lktake_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            ovalid_reg  <= ovalid_next;
            lktake_reg  <= lktake_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        want_reg    <= want_next;
        pg_reg      <= pg_next;
        g_reg       <= g_next;
        prev_reg    <= prev_next;
        prevh_reg   <= prevh_next;
        cur_reg     <= cur_next;
        curh_reg    <= curh_next;
        lnk_reg     <= lnk_next;
        lnkh_reg    <= lnkh_next;
        tk_reg      <= tk_next;
        tksz_reg    <= tksz_next;
        gbafter_reg <= gbafter_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
    end

`ifndef SYNTHESIS
    // A result is offered only after the sequencer finished a request.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // No new beat is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !s_tready)
        else $error("beat accepted while a result is pending");

    // A null or out-of-memory status never carries an address.
    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && st_reg != ST_DONE) |-> (res_reg == '0))
        else $error("failed request returned an address");

    // The sequencer is always in exactly one state.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
//==============================================================================
// tb_top
// Testbench for the first-fit heap allocator. It sends a short table of
// directed requests and then random allocate, release and resize traffic.
// The traffic reuses the addresses that were handed out earlier. Every result
// beat is checked against a software copy of the free list or a typed table
// entry, while both stream sides idle and stall at random.
//==============================================================================
module tb_top;

    import ffha_pkg::*;

    localparam int ARENA   = ARENA_GRANULES_DEF;
    localparam int HDR     = HEADER_GRANULES_DEF;
    localparam int NIL     = ARENA;
    localparam int N_RAND  = 1450;
    localparam int LIMIT   = 20_000_000;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } heap_result_t;

    typedef struct {
        logic [1:0]  action;
        logic [16:0] size_bytes;
        logic [15:0] address;
        bit          typed;
        logic [15:0] exp_addr;
        logic [1:0]  exp_status;
    } request_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    // Software copy of the header store and the free list.
    int unsigned blk_size [ARENA];
    int unsigned blk_next [ARENA];
    bit          blk_free [ARENA];
    int unsigned free_head;

    heap_result_t pending_results[$];
    logic [15:0]  live_addrs[$];
    logic [15:0]  issued_addrs[$];
    int unsigned  cycle_count;
    bit           failed = 1'b0;
    bit           stim_done;

    first_fit_heap_allocator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Link a free block into the address-ordered list.
    function automatic void list_insert(int unsigned g);
        int unsigned prev;
        int unsigned cur;
        prev = NIL;
        cur  = free_head;
        while (cur < NIL && cur < g)
        begin
            prev = cur;
            cur  = blk_next[cur];
        end
        if (cur == g)
            return;
        blk_next[g] = (cur < NIL) ? cur : NIL;
        if (prev >= NIL)
            free_head = g;
        else
            blk_next[prev] = g;
    endfunction

    // Merge every pair of listed blocks that touch each other.
    function automatic void list_coalesce();
        int unsigned cur;
        int unsigned nx;
        int unsigned sum;
        cur = free_head;
        while (cur < NIL)
        begin
            nx = blk_next[cur];
            if (nx >= NIL)
                break;
            if (cur + HDR + blk_size[cur] == nx)
            begin
                sum           = blk_size[cur] + HDR + blk_size[nx];
                blk_size[cur] = (sum > ARENA) ? ARENA : sum;
                blk_next[cur] = blk_next[nx];
            end
            else
                cur = nx;
        end
    endfunction

    // First fit: returns the payload granule, or 0 when nothing fits.
    function automatic int unsigned first_fit(int unsigned want);
        int unsigned prev;
        int unsigned cur;
        int unsigned rest_at;
        prev = NIL;
        cur  = free_head;
        while (cur < NIL)
        begin
            if (blk_free[cur] && blk_size[cur] >= want)
            begin
                rest_at = cur + HDR + want;
                if (prev >= NIL)
                    free_head = blk_next[cur];
                else
                    blk_next[prev] = blk_next[cur];
                if (blk_size[cur] >= want + 2 * HDR + 1 && rest_at < NIL)
                begin
                    blk_size[rest_at] = blk_size[cur] - want - HDR;
                    blk_free[rest_at] = 1'b1;
                    list_insert(rest_at);
                    blk_size[cur] = want;
                end
                blk_free[cur] = 1'b0;
                blk_next[cur] = NIL;
                return cur + HDR;
            end
            prev = cur;
            cur  = blk_next[cur];
        end
        return 0;
    endfunction

    function automatic void block_release(int unsigned g);
        if (blk_free[g])
            return;
        blk_free[g] = 1'b1;
        list_insert(g);
        list_coalesce();
    endfunction

    // Works out the result of one request and updates the copy of the heap.
    function automatic heap_result_t heap_predict(logic [1:0] action,
                                                  logic [16:0] size_bytes,
                                                  logic [15:0] address);
        int unsigned  want;
        int unsigned  pg;
        int unsigned  g;
        int unsigned  res;
        bit           is_null;
        heap_result_t r;
        want     = (32'(size_bytes) + 32'd7) >> 3;
        pg       = 32'(address >> 3);
        is_null  = (pg < HDR) || (pg - HDR >= NIL);
        g        = is_null ? 0 : pg - HDR;
        res      = 0;
        r.status = ST_DONE;
        if (action == ACT_RELEASE)
        begin
            if (is_null)
                r.status = ST_NULL;
            else
                block_release(g);
        end
        else if (action == ACT_ALLOC || is_null)
        begin
            if (want == 0)
                r.status = ST_NULL;
            else
            begin
                res = first_fit(want);
                if (res == 0)
                    r.status = ST_OOM;
            end
            res = res << 3;
        end
        else if (want == 0)
        begin
            block_release(g);
            r.status = ST_NULL;
        end
        else if (want <= blk_size[g])
        begin
            blk_size[g] = want;
            res         = pg << 3;
        end
        else
        begin
            res = first_fit(want);
            if (res == 0)
                r.status = ST_OOM;
            else
                block_release(g);
            res = res << 3;
        end
        r.addr = res[15:0];
        return r;
    endfunction

    // Drives one beat at the falling edge and waits for its acceptance.
    task automatic send_request(logic [1:0] action, logic [16:0] size_bytes,
                                logic [15:0] address);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {5'd0, address, size_bytes, action};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Random gap between bursts of beats.
    task automatic maybe_pause(ref int burst_left);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
        gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    // Records which addresses may be released or resized later.
    function automatic void track_addresses(logic [1:0] action, logic [16:0] size_bytes,
                                            logic [15:0] address, int live_idx,
                                            heap_result_t r);
        bit freed;
        bit is_null;
        is_null = (address >> 3) < HDR;
        freed   = 1'b0;
        if (!is_null && action == ACT_RELEASE)
            freed = 1'b1;
        if (!is_null && action == ACT_RESIZE)
            freed = (size_bytes == 0) ||
                    (r.status == ST_DONE && r.addr != {address[15:3], 3'd0});
        if (freed && live_idx >= 0)
            live_addrs.delete(live_idx);
        if (r.addr != 0 && r.addr != {address[15:3], 3'd0})
        begin
            live_addrs.push_back(r.addr);
            issued_addrs.push_back(r.addr);
        end
    endfunction

    // Directed table: reset state, extremes, null and double release, resize paths.
    request_row_t directed_rows[17] = '{
        '{ACT_ALLOC,   17'd0,     16'd0,  1'b1, 16'd0,  ST_NULL},
        '{ACT_RELEASE, 17'd0,     16'd0,  1'b1, 16'd0,  ST_NULL},
        '{ACT_ALLOC,   17'd65536, 16'd0,  1'b1, 16'd0,  ST_OOM},
        '{ACT_ALLOC,   17'd8,     16'd0,  1'b1, 16'd24, ST_DONE},
        '{ACT_ALLOC,   17'd100,   16'd0,  1'b0, 16'd0,  ST_DONE},
        '{ACT_RELEASE, 17'd0,     16'd24, 1'b1, 16'd0,  ST_DONE},
        '{ACT_RELEASE, 17'd0,     16'd24, 1'b1, 16'd0,  ST_DONE},
        '{ACT_RELEASE, 17'd1,     16'd31, 1'b0, 16'd0,  ST_DONE},
        '{ACT_RESIZE,  17'd0,     16'd0,  1'b1, 16'd0,  ST_NULL},
        '{ACT_RESIZE,  17'd16,    16'd0,  1'b0, 16'd0,  ST_DONE},
        '{ACT_RESIZE,  17'd50,    16'd56, 1'b0, 16'd0,  ST_DONE},
        '{ACT_RESIZE,  17'd2000,  16'd56, 1'b0, 16'd0,  ST_DONE},
        '{ACT_RESIZE,  17'd0,     16'd56, 1'b0, 16'd0,  ST_DONE},
        '{ACT_ALLOC,   17'd65512, 16'd0,  1'b0, 16'd0,  ST_DONE},
        '{ACT_RELEASE, 17'd0,     16'd16, 1'b1, 16'd0,  ST_NULL},
        '{ACT_RESIZE,  17'd65536, 16'd24, 1'b0, 16'd0,  ST_DONE},
        '{ACT_ALLOC,   17'd65535, 16'd0,  1'b0, 16'd0,  ST_DONE}
    };

    // Stimulus.
    initial
    begin
        heap_result_t r;
        logic [1:0]   action;
        logic [16:0]  size_bytes;
        logic [15:0]  address;
        int           live_idx;
        int           burst_left;
        int           pick;

        s_tvalid   = 1'b0;
        s_tdata    = '0;
        rst_n      = 1'b0;
        stim_done  = 1'b0;
        burst_left = 0;
        foreach (blk_size[i])
        begin
            blk_size[i] = 0;
            blk_next[i] = 0;
            blk_free[i] = 1'b0;
        end
        blk_size[0] = ARENA - HDR;
        blk_free[0] = 1'b1;
        blk_next[0] = NIL;
        free_head   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            r = heap_predict(directed_rows[i].action, directed_rows[i].size_bytes,
                             directed_rows[i].address);
            track_addresses(directed_rows[i].action, directed_rows[i].size_bytes,
                            directed_rows[i].address, -1, r);
            if (directed_rows[i].typed)
            begin
                r.addr   = directed_rows[i].exp_addr;
                r.status = directed_rows[i].exp_status;
            end
            maybe_pause(burst_left);
            send_request(directed_rows[i].action, directed_rows[i].size_bytes,
                         directed_rows[i].address);
            pending_results.push_back(r);
        end
        live_addrs = {};
        foreach (issued_addrs[i])
            live_addrs.push_back(issued_addrs[i]);

        for (int n = 0; n < N_RAND; n++)
        begin
            live_idx = -1;
            pick     = $urandom_range(0, 99);
            if (live_addrs.size() > 120)
                pick = 50 + pick / 2;
            action = (pick < 45) ? ACT_ALLOC : (pick < 80) ? ACT_RELEASE : ACT_RESIZE;

            // Mostly small blocks, a few large ones and the odd extreme.
            pick = $urandom_range(0, 99);
            if (pick < 80)
                size_bytes = 17'($urandom_range(1, 256));
            else if (pick < 95)
                size_bytes = 17'($urandom_range(257, 4096));
            else if (pick < 97)
                size_bytes = '0;
            else
                size_bytes = 17'($urandom_range(4097, 65536));

            // Release and resize addresses mostly come from earlier results, with random low bits.
            pick = $urandom_range(0, 99);
            if (action == ACT_ALLOC)
                address = 16'($urandom);
            else if (pick < 5 || issued_addrs.size() == 0)
                address = 16'($urandom_range(0, HDR * 8 - 1));
            else if (pick < 85 && live_addrs.size() > 0)
            begin
                live_idx = $urandom_range(0, live_addrs.size() - 1);
                address  = live_addrs[live_idx] | 16'($urandom_range(0, 7));
            end
            else
                address = issued_addrs[$urandom_range(0, issued_addrs.size() - 1)]
                          | 16'($urandom_range(0, 7));

            r = heap_predict(action, size_bytes, address);
            track_addresses(action, size_bytes, address, live_idx, r);
            maybe_pause(burst_left);
            send_request(action, size_bytes, address);
            pending_results.push_back(r);
        end
        @(negedge clk);
        s_tvalid  = 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stalls: randomly chosen stretches of free flow and of random stalls.
    initial
    begin
        int stretch;
        bit choppy;
        m_tready = 1'b0;
        forever
        begin
            choppy  = $urandom_range(0, 2) != 0;
            stretch = $urandom_range(10, 80);
            repeat (stretch)
            begin
                @(negedge clk);
                m_tready = choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
            end
        end
    end

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        heap_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request pending: %h", m_tdata);
                failed <= 1'b1;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tdata[15:0] !== exp_r.addr)
                begin
                    $error("result_address expected %0d actual %0d", exp_r.addr,
                           m_tdata[15:0]);
                    failed <= 1'b1;
                end
                if (m_tdata[17:16] !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status,
                           m_tdata[17:16]);
                    failed <= 1'b1;
                end
            end
        end
    end

    // End of run and timeout.
    initial
    begin
        cycle_count = 0;
        while (!(stim_done && pending_results.size() == 0) && cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= LIMIT)
        begin
            $display("[first_fit_heap_allocator_unit] ERROR");
            $finish;
        end
        else
        begin
            repeat (200) @(posedge clk);
            if (!failed && pending_results.size() == 0)
                $display("[first_fit_heap_allocator_unit] OK");
            else
                $display("[first_fit_heap_allocator_unit] ERROR");
            $finish;
        end
    end

endmodule
